### hw/rtl/pes_pkg.sv
package pes_pkg;

   // sequencer state codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BLEND = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   typedef logic [2:0] state_type;

endpackage

### hw/rtl/plane_estimate_smoother.sv
// channel | dir | tdata (low bit up)                          | tuser
// req_    | in  | new_point_x/y/z, new_normal_x/y/z, pad      | -
// rsp_    | out | plane_point_x/y/z, plane_normal_x/y/z, pad  | updated
// csr_    | in  | smoothing_gain                              | -
//
// For a passing item, one shared multiplier does the six blends and three squares,
// a one-bit-per-cycle square root finds the length and a one-bit-per-cycle divider
// normalizes each component. A gated-out item skips these steps. Synchronous reset
// restores the kept plane and the gain. The result sits in an output register, so a
// stalled rsp_ side holds the next item only once it is finished.
module plane_estimate_smoother #(
   parameter int POINT_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // new_point_x, new_point_y, new_point_z, new_normal_x, new_normal_y, new_normal_z
   input  logic [((3*POINT_BITS+3*(FRAC_BITS+2)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // plane_point_x/y/z, plane_normal_x/y/z
   output logic [((3*POINT_BITS+3*(FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // updated
   output logic rsp_tuser,
   input  logic csr_wen,
   input  logic [FRAC_BITS:0] csr_wdata
);
   import pes_pkg::*;

   localparam int P   = POINT_BITS;
   localparam int F   = FRAC_BITS;
   localparam int NB  = F + 2;
   localparam int GB  = F + 1;
   localparam int DW  = ((P > NB) ? P : NB) + 1;
   localparam int PW  = DW + NB;
   localparam int SW  = 2 * F + 4;
   localparam int RW  = F + 2;
   localparam int QW  = 2 * F + 2;
   localparam int TW  = ((3*P + 3*NB + 7) / 8) * 8;
   localparam int CW  = $clog2(QW + 1);
   localparam int PAD = TW - 3*P - 3*NB;
   localparam logic [GB-1:0] ONE_Q  = GB'(1) << F;
   localparam logic [NB-1:0] GATE_Q = NB'((4 * (64'd1 << F) + 4) / 5);

   state_type         state_ff;
   logic [2:0]        k_ff;
   logic              phase_ff;
   logic [CW-1:0]     cnt_ff;
   logic [GB-1:0]     gain_ff;
   logic signed [P-1:0]  pt_ff [3];
   logic signed [NB-1:0] nm_ff [3];
   logic signed [P-1:0]  np_ff [3];
   logic signed [NB-1:0] nn_ff [3];
   logic              upd_ff;
   logic [PW-1:0]     prod_ff;
   logic              neg_ff;
   logic [SW-1:0]     sum_ff;
   logic [SW-1:0]     sh_ff;
   logic [RW+3:0]     srem_ff;
   logic [RW-1:0]     root_ff;
   logic [QW-1:0]     num_ff;
   logic [RW-1:0]     drem_ff;
   logic [QW-1:0]     quo_ff;
   logic              rsp_valid_ff;
   logic [TW-1:0]     rsp_data_ff;
   logic              rsp_user_ff;

   // operand selection for the shared multiplier
   logic [1:0]           kk;
   logic signed [DW-1:0] old_v, new_v, dif, blended;
   logic [DW-1:0]        ad, step;
   logic [GB-1:0]        gain_sat;
   logic [NB-1:0]        nabs;
   logic [DW-1:0]        mul_a;
   logic [NB-1:0]        mul_b;
   logic [NB-1:0]        nz_abs;

   assign kk       = (k_ff >= 3'd3) ? 2'(k_ff - 3'd3) : k_ff[1:0];
   assign gain_sat = (gain_ff > ONE_Q) ? ONE_Q : gain_ff;
   assign old_v    = (k_ff >= 3'd3) ? DW'(nm_ff[kk]) : DW'(pt_ff[kk]);
   assign new_v    = (k_ff >= 3'd3) ? DW'(nn_ff[kk]) : DW'(np_ff[kk]);
   assign dif      = new_v - old_v;
   assign ad       = dif[DW-1] ? DW'(-dif) : DW'(dif);
   assign step     = DW'(prod_ff >> F);
   assign blended  = neg_ff ? (old_v - signed'(step)) : (old_v + signed'(step));
   assign nabs     = nm_ff[kk][NB-1] ? NB'(-nm_ff[kk]) : NB'(nm_ff[kk]);
   assign mul_a    = (state_ff == ST_BLEND) ? ad : DW'(nabs);
   assign mul_b    = (state_ff == ST_BLEND) ? NB'(gain_sat) : nabs;

   // square root step, two bits of the sum per cycle
   logic [RW+3:0] srem_sh, strial;
   assign srem_sh = {srem_ff[RW+1:0], sh_ff[SW-1:SW-2]};
   assign strial  = (RW+4)'({root_ff, 2'b01});

   // division step, one quotient bit per cycle
   logic [RW-1:0] len;
   logic [RW:0]   drem_sh;
   assign len     = (root_ff == '0) ? RW'(1) : root_ff;
   assign drem_sh = {drem_ff, num_ff[QW-1]};

   // gate on the incoming normal z
   logic signed [NB-1:0] req_nz;
   assign req_nz = req_tdata[3*P+3*NB-1 -: NB];
   assign nz_abs = req_nz[NB-1] ? NB'(-req_nz) : NB'(req_nz);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GB'(1) << (F - 1);
         for (int i = 0; i < 3; i++) begin
            pt_ff[i] <= '0;
            nm_ff[i] <= (i == 2) ? NB'(ONE_Q) : '0;
         end
         k_ff     <= '0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_wen) begin
            gain_ff <= csr_wdata;
         end
         // output register empties on a taken transaction unless refilled below
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < 3; i++) begin
                     np_ff[i] <= req_tdata[i*P +: P];
                     nn_ff[i] <= req_tdata[3*P + i*NB +: NB];
                  end
                  upd_ff   <= (nz_abs >= GATE_Q);
                  k_ff     <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= (nz_abs >= GATE_Q) ? ST_BLEND : ST_DONE;
               end
            end
            ST_BLEND: begin
               if (!phase_ff) begin
                  prod_ff  <= PW'(mul_a) * PW'(mul_b);
                  neg_ff   <= dif[DW-1];
                  phase_ff <= 1'b1;
               end else begin
                  if (k_ff >= 3'd3) nm_ff[kk] <= NB'(blended);
                  else pt_ff[kk] <= P'(blended);
                  phase_ff <= 1'b0;
                  if (k_ff == 3'd5) begin
                     k_ff     <= '0;
                     sum_ff   <= '0;
                     state_ff <= ST_SQUARE;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            ST_SQUARE: begin
               if (!phase_ff) begin
                  prod_ff  <= PW'(mul_a) * PW'(mul_b);
                  phase_ff <= 1'b1;
               end else begin
                  phase_ff <= 1'b0;
                  if (k_ff == 3'd2) begin
                     sh_ff    <= sum_ff + SW'(prod_ff);
                     srem_ff  <= '0;
                     root_ff  <= '0;
                     cnt_ff   <= '0;
                     state_ff <= ST_SQRT;
                  end else begin
                     sum_ff <= sum_ff + SW'(prod_ff);
                     k_ff   <= k_ff + 3'd1;
                  end
               end
            end
            ST_SQRT: begin
               sh_ff <= sh_ff << 2;
               if (srem_sh >= strial) begin
                  srem_ff <= srem_sh - strial;
                  root_ff <= {root_ff[RW-2:0], 1'b1};
               end else begin
                  srem_ff <= srem_sh;
                  root_ff <= {root_ff[RW-2:0], 1'b0};
               end
               if (cnt_ff == CW'(SW/2 - 1)) begin
                  cnt_ff   <= '0;
                  k_ff     <= 3'd3;
                  phase_ff <= 1'b0;
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_DIV: begin
               if (!phase_ff) begin
                  // magnitude scaled up by one unit
                  num_ff   <= QW'(nabs) << F;
                  drem_ff  <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  phase_ff <= 1'b1;
               end else if (cnt_ff != CW'(QW)) begin
                  num_ff <= num_ff << 1;
                  if (drem_sh >= (RW+1)'(len)) begin
                     drem_ff <= RW'(drem_sh - (RW+1)'(len));
                     quo_ff  <= {quo_ff[QW-2:0], 1'b1};
                  end else begin
                     drem_ff <= RW'(drem_sh);
                     quo_ff  <= {quo_ff[QW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + CW'(1);
               end else begin
                  nm_ff[kk] <= nm_ff[kk][NB-1] ? NB'(-quo_ff) : NB'(quo_ff);
                  phase_ff  <= 1'b0;
                  if (k_ff == 3'd5) state_ff <= ST_DONE;
                  else k_ff <= k_ff + 3'd1;
               end
            end
            ST_DONE: begin
               // load the result once the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= upd_ff;
                  rsp_data_ff  <= {{PAD{1'b0}}, nm_ff[2], nm_ff[1], nm_ff[0],
                                   pt_ff[2], pt_ff[1], pt_ff[0]};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
